@@ src/mes_pkg.sv @@
// shared types, constants and helpers for the meter energy and scaling block
// no dependencies; imported by every module under src
package mes_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam int unsigned DivW = 40;
  localparam int unsigned DsrW = 24;
  localparam int unsigned DivCntW = $clog2(DivW + 1);

  typedef enum logic {
    CMD_PULSE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_VOLT_GAIN   = 2'd0,
    CFG_POWER_GAIN  = 2'd1,
    CFG_METER_CONST = 2'd2,
    CFG_SAVE_GAP    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [23:0] raw_voltage;
    logic [31:0] raw_power;
  } in_item_t;

  typedef struct packed {
    logic [15:0] voltage;
    logic [31:0] power;
    logic [15:0] current;
    logic [31:0] energy;
    logic        save_now;
    logic [31:0] save_value;
  } out_item_t;

  typedef struct packed {
    logic [23:0] volt_gain;
    logic [23:0] power_gain;
    logic [15:0] meter_constant;
    logic [15:0] save_gap;
  } cfg_t;

  typedef struct packed {
    logic        is_sample;
    logic [23:0] raw_v;
    logic [34:0] rp10;
    logic [39:0] etot100;
    logic        save_now;
    logic [31:0] save_value;
  } job_t;

  typedef struct packed {
    logic                 start;
    logic [DivW-1:0]      dividend;
    logic [DsrW-1:0]      divisor;
    logic [DivCntW-1:0]   nbits;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quot;
  } div_rsp_t;

  function automatic logic [DsrW-1:0] nonzero24(input logic [DsrW-1:0] d);
    return (d == '0) ? DsrW'(1) : d;
  endfunction

endpackage

@@ src/meter_energy_and_scaling.sv @@
// Meter energy and scaling. Energy pulses and raw voltage/power samples enter on one
// valid/ready channel; each gives one result on the output channel. A pulse runs
// only energy, a sample up to all four, on one shared divider giving one quotient
// bit per cycle (24, 35, 36 and 40 steps for voltage, power, current and energy). A
// two-entry queue lets new items be taken while a division runs or a result waits.
// Configuration writes are accepted every cycle and should be made only while idle.
// depends on mes_pkg, mes_front, mes_queue, mes_back
module meter_energy_and_scaling (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mes_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mes_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  mes_pkg::cfg_idx_e  cfg_index_i,
  input  logic [23:0]        cfg_data_i
);
  import mes_pkg::*;

  cfg_t cfg_q;
  logic push, pop, full, empty;
  job_t job, head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.volt_gain      <= 24'd1;
      cfg_q.power_gain     <= 24'd1;
      cfg_q.meter_constant <= 16'd3200;
      cfg_q.save_gap       <= 16'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_VOLT_GAIN:   cfg_q.volt_gain      <= cfg_data_i;
        CFG_POWER_GAIN:  cfg_q.power_gain     <= cfg_data_i;
        CFG_METER_CONST: cfg_q.meter_constant <= cfg_data_i[15:0];
        CFG_SAVE_GAP:    cfg_q.save_gap       <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  mes_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .save_gap_i (cfg_q.save_gap),
    .full_i     (full),
    .push_o     (push),
    .job_o      (job)
  );

  mes_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (job),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  mes_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  a_save_only_on_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.save_now |->
      out_item_o.voltage == '0 && out_item_o.power == '0 && out_item_o.current == '0)
    else $error("save request on a sample result");

  a_save_value_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.save_now |-> out_item_o.save_value == '0)
    else $error("save value without save request");

  a_current_needs_voltage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.current != '0 |-> out_item_o.voltage != '0)
    else $error("nonzero current with zero voltage");

endmodule

@@ src/mes_div.sv @@
// shared restoring divider, one quotient bit per cycle
// depends on mes_pkg
module mes_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mes_pkg::div_req_t req_i,
  output mes_pkg::div_rsp_t rsp_o
);
  import mes_pkg::*;

  logic               busy_q, done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DivW-1:0]    dq_q;
  logic [DsrW-1:0]    rem_q, dsr_q;

  logic [DsrW:0]   rem_sh;
  logic [DsrW+1:0] diff;
  logic            take;

  assign rem_sh = {rem_q, dq_q[DivW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b0, dsr_q};
  assign take   = !diff[DsrW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !req_i.start && busy_q && (cnt_q == DivCntW'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.nbits;
      end else if (busy_q) begin
        cnt_q <= cnt_q - DivCntW'(1);
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dq_q  <= req_i.dividend;
      dsr_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dq_q  <= {dq_q[DivW-2:0], take};
      rem_q <= take ? diff[DsrW-1:0] : rem_sh[DsrW-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dq_q;

endmodule

@@ src/mes_queue.sv @@
// short job queue between the front and back parts
// depends on mes_pkg
module mes_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mes_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output mes_pkg::job_t head_o
);
  import mes_pkg::*;

  job_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ src/mes_front.sv @@
// front part: accepts items, keeps the pulse counters, builds jobs
// depends on mes_pkg
module mes_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mes_pkg::in_item_t in_item_i,
  input  logic [15:0]      save_gap_i,
  input  logic             full_i,
  output logic             push_o,
  output mes_pkg::job_t    job_o
);
  import mes_pkg::*;

  logic [31:0] saved_total_q, saved_total_d;
  logic [15:0] pending_q, pending_d;

  logic [15:0] gap, pend_inc;
  logic        fold;
  logic [32:0] fold_sum, total;
  logic [31:0] fold_total;
  logic [23:0] rv;
  logic [31:0] rp;
  logic        is_pulse;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;
  assign is_pulse   = (in_item_i.cmd == CMD_PULSE);

  always_comb begin
    gap        = (save_gap_i == '0) ? 16'd1 : save_gap_i;
    pend_inc   = (pending_q == 16'hFFFF) ? pending_q : pending_q + 16'd1;
    fold       = (pend_inc >= gap);
    fold_sum   = {1'b0, saved_total_q} + {17'b0, pend_inc};
    fold_total = fold_sum[32] ? 32'hFFFF_FFFF : fold_sum[31:0];

    saved_total_d = saved_total_q;
    pending_d     = pending_q;
    if (is_pulse) begin
      if (fold) begin
        saved_total_d = fold_total;
        pending_d     = '0;
      end else begin
        pending_d = pend_inc;
      end
    end
    total = {1'b0, saved_total_d} + {17'b0, pending_d};

    rv = in_item_i.raw_voltage[23] ? '0 : in_item_i.raw_voltage;
    rp = in_item_i.raw_power[31] ? '0 : in_item_i.raw_power;

    job_o.is_sample  = !is_pulse;
    job_o.raw_v      = rv;
    job_o.rp10       = ({3'b0, rp} << 3) + ({3'b0, rp} << 1);
    job_o.etot100    = ({7'b0, total} << 6) + ({7'b0, total} << 5) + ({7'b0, total} << 2);
    job_o.save_now   = is_pulse && fold;
    job_o.save_value = (is_pulse && fold) ? fold_total : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      saved_total_q <= '0;
      pending_q     <= '0;
    end else if (push_o) begin
      saved_total_q <= saved_total_d;
      pending_q     <= pending_d;
    end
  end

endmodule

@@ src/mes_back.sv @@
// back part: runs the scaling divisions on the shared divider, holds the result
// depends on mes_pkg and mes_div
module mes_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mes_pkg::cfg_t      cfg_i,
  input  logic               empty_i,
  input  mes_pkg::job_t      head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mes_pkg::out_item_t out_item_o
);
  import mes_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VOLT,
    ST_POWER,
    ST_CURR,
    ST_ENERGY,
    ST_DONE
  } state_e;

  state_e      state_q;
  logic        launched_q;
  job_t        job_q;
  logic [15:0] v_q, i_q;
  logic [31:0] p_q, e_q;
  logic        out_valid_q;
  out_item_t   out_q;

  div_req_t    req;
  div_rsp_t    rsp;
  logic [35:0] p10;

  mes_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign p10   = ({4'b0, p_q} << 3) + ({4'b0, p_q} << 1);
  assign pop_o = (state_q == ST_IDLE) && !empty_i;

  always_comb begin
    req = '0;
    unique case (state_q)
      ST_VOLT: begin
        req.start    = !launched_q;
        req.dividend = {job_q.raw_v, 16'b0};
        req.divisor  = nonzero24(cfg_i.volt_gain);
        req.nbits    = DivCntW'(24);
      end
      ST_POWER: begin
        req.start    = !launched_q;
        req.dividend = {job_q.rp10, 5'b0};
        req.divisor  = nonzero24(cfg_i.power_gain);
        req.nbits    = DivCntW'(35);
      end
      ST_CURR: begin
        req.start    = !launched_q && (v_q != '0);
        req.dividend = {p10, 4'b0};
        req.divisor  = {8'b0, v_q};
        req.nbits    = DivCntW'(36);
      end
      ST_ENERGY: begin
        req.start    = !launched_q;
        req.dividend = job_q.etot100;
        req.divisor  = nonzero24({8'b0, cfg_i.meter_constant});
        req.nbits    = DivCntW'(40);
      end
      default: req = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      launched_q  <= 1'b0;
      out_valid_q <= 1'b0;
      job_q       <= '0;
      v_q         <= '0;
      p_q         <= '0;
      i_q         <= '0;
      e_q         <= '0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      if (req.start) begin
        launched_q <= 1'b1;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            job_q   <= head_i;
            v_q     <= '0;
            p_q     <= '0;
            i_q     <= '0;
            state_q <= head_i.is_sample ? ST_VOLT : ST_ENERGY;
          end
        end
        ST_VOLT: begin
          if (rsp.done) begin
            v_q        <= rsp.quot[15:0];
            launched_q <= 1'b0;
            state_q    <= ST_POWER;
          end
        end
        ST_POWER: begin
          if (rsp.done) begin
            p_q        <= (rsp.quot[39:32] != '0) ? 32'hFFFF_FFFF : rsp.quot[31:0];
            launched_q <= 1'b0;
            state_q    <= ST_CURR;
          end
        end
        ST_CURR: begin
          if (v_q == '0) begin
            i_q     <= '0;
            state_q <= ST_ENERGY;
          end else if (rsp.done) begin
            i_q        <= (rsp.quot[39:16] != '0) ? 16'hFFFF : rsp.quot[15:0];
            launched_q <= 1'b0;
            state_q    <= ST_ENERGY;
          end
        end
        ST_ENERGY: begin
          if (rsp.done) begin
            e_q        <= (rsp.quot[39:32] != '0) ? 32'hFFFF_FFFF : rsp.quot[31:0];
            launched_q <= 1'b0;
            state_q    <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.voltage    <= v_q;
            out_q.power      <= p_q;
            out_q.current    <= i_q;
            out_q.energy     <= e_q;
            out_q.save_now   <= job_q.save_now;
            out_q.save_value <= job_q.save_value;
            out_valid_q      <= 1'b1;
            state_q          <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
